[hw/rtl/yuyv_to_framebuffer_pixel_writer_defines.svh]
// Assertion macros for the YUYV to framebuffer pixel writer.
`ifndef YUYV_TO_FRAMEBUFFER_PIXEL_WRITER_DEFINES_SVH
`define YUYV_TO_FRAMEBUFFER_PIXEL_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
`define YTFPW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`define YTFPW_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define YTFPW_ASSERT(lbl, prop, msg)
`define YTFPW_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[hw/rtl/ytfpw_pkg.sv]
// Shared types, constants and helpers for the YUYV to framebuffer pixel writer.
`timescale 1ns / 1ps

package ytfpw_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int DIM_W      = 13;
    localparam int LINE_W     = 15;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int COL_W      = $clog2(MAX_WIDTH / 2);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int OFF_W      = 26;
    localparam int WORD_W     = 32;
    localparam int BC_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE  = 3'd5;

    localparam logic [MODE_W-1:0] MODE_BGRX   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BGR    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RGB565 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [BC_W-1:0] BYTES_BGRX   = 3'd4;
    localparam logic [BC_W-1:0] BYTES_BGR    = 3'd3;
    localparam logic [BC_W-1:0] BYTES_RGB565 = 3'd2;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
    } t_in_word;

    typedef struct packed {
        logic [OFF_W-1:0]  fb_offset;
        logic [WORD_W-1:0] pixel_word;
        logic [BC_W-1:0]   byte_count;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic [DIM_W-1:0]  src_width;
        logic [DIM_W-1:0]  src_height;
        logic [DIM_W-1:0]  disp_width;
        logic [DIM_W-1:0]  disp_height;
        logic [LINE_W-1:0] line_bytes;
        logic [MODE_W-1:0] pixel_mode;
    } t_cfg;

    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [ROW_W-1:0] y;
        logic             visible;
        logic             two;
    } t_pos;

    function automatic logic [7:0] clamp_u8(input logic signed [19:0] t);
        logic [7:0] res;
        if (t[19]) begin
            res = 8'd0;
        end else if (t[18:16] != 3'd0) begin
            res = 8'd255;
        end else begin
            res = t[15:8];
        end
        return res;
    endfunction

endpackage

[hw/rtl/ytfpw_cfg.sv]
// Configuration register file.
`timescale 1ns / 1ps

module ytfpw_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ytfpw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ytfpw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output ytfpw_pkg::t_cfg                     o_cfg
);
    import ytfpw_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width   <= DIM_W'(640);
            r_cfg.src_height  <= DIM_W'(480);
            r_cfg.disp_width  <= DIM_W'(800);
            r_cfg.disp_height <= DIM_W'(480);
            r_cfg.line_bytes  <= LINE_W'(3200);
            r_cfg.pixel_mode  <= MODE_BGRX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_WIDTH:   r_cfg.src_width   <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT:  r_cfg.src_height  <= i_cfg_data[DIM_W-1:0];
                CFG_DISP_WIDTH:  r_cfg.disp_width  <= i_cfg_data[DIM_W-1:0];
                CFG_DISP_HEIGHT: r_cfg.disp_height <= i_cfg_data[DIM_W-1:0];
                CFG_LINE_BYTES:  r_cfg.line_bytes  <= i_cfg_data[LINE_W-1:0];
                CFG_PIXEL_MODE:  r_cfg.pixel_mode  <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/ytfpw_pos.sv]
// Macropixel position tracker and crop window check.
`timescale 1ns / 1ps

module ytfpw_pos (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_frame_start,
    input  ytfpw_pkg::t_cfg   i_cfg,
    output ytfpw_pkg::t_pos   o_pos
);
    import ytfpw_pkg::*;

    logic [COL_W-1:0] r_col, n_col, cur_col;
    logic [ROW_W-1:0] r_row, n_row, cur_row;
    logic [DIM_W-1:0] sw_c, sh_c, show_w, show_h, sw_p1;
    logic [COL_W:0]   pairs, col_inc;
    logic [ROW_W:0]   row_inc;
    logic [X_W-1:0]   x;

    always_comb begin
        sw_c = i_cfg.src_width;
        if (sw_c < DIM_W'(2)) begin
            sw_c = DIM_W'(2);
        end else if (sw_c > DIM_W'(MAX_WIDTH)) begin
            sw_c = DIM_W'(MAX_WIDTH);
        end
        sh_c = i_cfg.src_height;
        if (sh_c < DIM_W'(1)) begin
            sh_c = DIM_W'(1);
        end else if (sh_c > DIM_W'(MAX_HEIGHT)) begin
            sh_c = DIM_W'(MAX_HEIGHT);
        end
        show_w = (sw_c < i_cfg.disp_width)  ? sw_c : i_cfg.disp_width;
        show_h = (sh_c < i_cfg.disp_height) ? sh_c : i_cfg.disp_height;
        sw_p1  = sw_c + DIM_W'(1);
        pairs  = (COL_W+1)'(sw_p1 >> 1);

        cur_col = (i_frame_start || ({1'b0, r_col} >= pairs)) ? '0 : r_col;
        cur_row = (i_frame_start || (DIM_W'(r_row) >= sh_c)) ? '0 : r_row;
        x       = {cur_col, 1'b0};

        col_inc = {1'b0, cur_col} + (COL_W+1)'(1);
        row_inc = {1'b0, cur_row} + (ROW_W+1)'(1);
        n_row   = cur_row;
        if (col_inc >= pairs) begin
            n_col = '0;
            n_row = (DIM_W'(row_inc) >= sh_c) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.x       = x;
    assign o_pos.y       = cur_row;
    assign o_pos.visible = (i_cfg.pixel_mode != MODE_NONE) &&
                           (DIM_W'(cur_row) < show_h) && (DIM_W'(x) < show_w);
    assign o_pos.two     = (DIM_W'(x) + DIM_W'(1)) < show_w;

endmodule

[hw/rtl/ytfpw_pixel.sv]
// BT.601 color conversion, pixel packing and framebuffer offset.
`timescale 1ns / 1ps

module ytfpw_pixel (
    input  logic [ytfpw_pkg::X_W-1:0]    i_x,
    input  logic [ytfpw_pkg::ROW_W-1:0]  i_y,
    input  logic [7:0]                   i_luma,
    input  logic [7:0]                   i_cb,
    input  logic [7:0]                   i_cr,
    input  logic [ytfpw_pkg::MODE_W-1:0] i_mode,
    input  logic [ytfpw_pkg::LINE_W-1:0] i_line_bytes,
    output logic [ytfpw_pkg::OFF_W-1:0]  o_fb_offset,
    output logic [ytfpw_pkg::WORD_W-1:0] o_pixel_word,
    output logic [ytfpw_pkg::BC_W-1:0]   o_byte_count
);
    import ytfpw_pkg::*;

    logic signed [19:0]          c, d, e, sum_r, sum_g, sum_b;
    logic [7:0]                  red, grn, blu;
    logic [BC_W-1:0]             bpp;
    logic [ROW_W+LINE_W-1:0]     row_base, sum_off;
    logic [X_W+2:0]              col_off;

    always_comb begin
        c = $signed({12'b0, i_luma}) - 20'sd16;
        d = $signed({12'b0, i_cb})   - 20'sd128;
        e = $signed({12'b0, i_cr})   - 20'sd128;
        sum_r = 20'sd298 * c + 20'sd409 * e + 20'sd128;
        sum_g = 20'sd298 * c - 20'sd100 * d - 20'sd208 * e + 20'sd128;
        sum_b = 20'sd298 * c + 20'sd516 * d + 20'sd128;
        red = clamp_u8(sum_r);
        grn = clamp_u8(sum_g);
        blu = clamp_u8(sum_b);

        case (i_mode)
            MODE_BGRX: begin
                bpp          = BYTES_BGRX;
                o_pixel_word = {8'd0, red, grn, blu};
            end
            MODE_BGR: begin
                bpp          = BYTES_BGR;
                o_pixel_word = {8'd0, red, grn, blu};
            end
            MODE_RGB565: begin
                bpp          = BYTES_RGB565;
                o_pixel_word = {16'd0, red[7:3], grn[7:2], blu[7:3]};
            end
            default: begin
                bpp          = BYTES_BGRX;
                o_pixel_word = {8'd0, red, grn, blu};
            end
        endcase

        row_base = (ROW_W+LINE_W)'(i_y) * (ROW_W+LINE_W)'(i_line_bytes);
        col_off  = (X_W+3)'(i_x) * (X_W+3)'(bpp);
        sum_off  = row_base + (ROW_W+LINE_W)'(col_off);
    end

    assign o_fb_offset  = sum_off[OFF_W-1:0];
    assign o_byte_count = bpp;

endmodule

[hw/rtl/yuyv_to_framebuffer_pixel_writer.sv]
// YUYV to framebuffer pixel writer: one YUYV macropixel in, up to two framebuffer
// pixel writes out. A macropixel is captured in the macropixel register in the
// cycle it is accepted; in each following cycle in which the output register is
// free, one of its pixels is converted and loaded into the output register. A
// macropixel with two visible pixels thus gives two words on the single result
// port, one with a single visible pixel gives one word, and one outside the crop
// window (or in the unsupported depth mode) is accepted and gives no word. The
// sustained rate inside the window is set by the result port, which takes one
// word per cycle while i_out_ready is high. The first result passes the macropixel register, then the output register.
`timescale 1ns / 1ps
`include "yuyv_to_framebuffer_pixel_writer_defines.svh"

module yuyv_to_framebuffer_pixel_writer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ytfpw_pkg::t_in_word                 i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ytfpw_pkg::t_out_word                o_out_word,
    input  logic                                i_cfg_we,
    input  logic [ytfpw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ytfpw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ytfpw_pkg::*;

    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [ROW_W-1:0] y;
        logic [7:0]       luma0;
        logic [7:0]       luma1;
        logic [7:0]       cb;
        logic [7:0]       cr;
        logic             two;
    } t_item;

    t_cfg       cfg;
    t_pos       pos;
    t_item      r_item;
    logic       r_item_valid;
    logic       r_sel;
    t_out_word  r_out;
    logic       r_out_valid;

    logic              out_free, emit, item_done, in_acc;
    logic [X_W-1:0]    pix_x;
    logic [7:0]        pix_luma;
    logic [OFF_W-1:0]  pix_off;
    logic [WORD_W-1:0] pix_word;
    logic [BC_W-1:0]   pix_bc;

    ytfpw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ytfpw_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (in_acc),
        .i_frame_start (i_in_word.frame_start),
        .i_cfg         (cfg),
        .o_pos         (pos)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign emit       = r_item_valid && out_free;
    assign item_done  = emit && (r_sel || !r_item.two);
    assign o_in_ready = !r_item_valid || item_done;
    assign in_acc     = i_in_valid && o_in_ready;

    assign pix_x    = {r_item.x[X_W-1:1], r_sel};
    assign pix_luma = r_sel ? r_item.luma1 : r_item.luma0;

    ytfpw_pixel u_pixel (
        .i_x          (pix_x),
        .i_y          (r_item.y),
        .i_luma       (pix_luma),
        .i_cb         (r_item.cb),
        .i_cr         (r_item.cr),
        .i_mode       (cfg.pixel_mode),
        .i_line_bytes (cfg.line_bytes),
        .o_fb_offset  (pix_off),
        .o_pixel_word (pix_word),
        .o_byte_count (pix_bc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_sel        <= 1'b0;
        end else begin
            if (in_acc && pos.visible) begin
                r_item_valid <= 1'b1;
                r_sel        <= 1'b0;
            end else if (item_done) begin
                r_item_valid <= 1'b0;
                r_sel        <= 1'b0;
            end else if (emit) begin
                r_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && pos.visible) begin
            r_item.x     <= pos.x;
            r_item.y     <= pos.y;
            r_item.luma0 <= i_in_word.luma_first;
            r_item.luma1 <= i_in_word.luma_second;
            r_item.cb    <= i_in_word.chroma_blue;
            r_item.cr    <= i_in_word.chroma_red;
            r_item.two   <= pos.two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.fb_offset  <= pix_off;
            r_out.pixel_word <= pix_word;
            r_out.byte_count <= pix_bc;
            r_out.last       <= item_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // second pixel only ever follows a macropixel that has one
    `YTFPW_ASSERT(a_sel_two, (r_item_valid && r_sel) |-> r_item.two, "second pixel without pair")
    // a non-final word leaves its macropixel pending
    `YTFPW_ASSERT(a_pending, (o_out_valid && !o_out_word.last) |-> r_item_valid, "lost second pixel")
    // a macropixel blocked by a full output stage holds off the input
    `YTFPW_ASSERT(a_block, (r_item_valid && !out_free) |-> !o_in_ready, "input taken over pending pixel")
    `YTFPW_ASSERT_NEXT(a_emit_valid, emit, o_out_valid, "emitted word not presented")
    `YTFPW_ASSERT(a_bc, o_out_valid |-> (o_out_word.byte_count == BYTES_BGRX || o_out_word.byte_count == BYTES_BGR || o_out_word.byte_count == BYTES_RGB565), "bad byte count")

endmodule

[bench/tb_yuyv_to_framebuffer_pixel_writer.sv]
// Self-checking testbench for the YUYV to framebuffer pixel writer.
`timescale 1ns / 1ps

module tb_yuyv_to_framebuffer_pixel_writer;
    import ytfpw_pkg::*;

    localparam int RANDOM_TARGET = 1800;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        int        n_fixed;
        t_out_word fix0;
        t_out_word fix1;
    } t_item_note;

    typedef struct {
        t_row_kind kind;
        t_cfg      cfg;
        t_in_word  w;
        int        n_fixed;
        t_out_word fix0;
        t_out_word fix1;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    yuyv_to_framebuffer_pixel_writer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: register shadow and raster position.
    t_cfg        shadow = '{640, 480, 800, 480, 3200, MODE_BGRX};
    int unsigned col_pair = 0;
    int unsigned row_idx = 0;

    t_out_word   expected_pixels[$];
    t_item_note  fixed_notes[$];
    t_dir_row    dir_rows[$];

    int          mismatches = 0;
    int          macropixels_in = 0;
    int          pixels_checked = 0;
    int          settings_loaded = 0;
    bit          calm = 1'b0;
    int          stall_cnt = 0;

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd235;
            4: return 8'd128;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] sat_channel(input int t);
        if (t < 0) return 8'd0;
        if ((t >>> 8) > 255) return 8'd255;
        return 8'(t >>> 8);
    endfunction

    function automatic void frame_geometry(output int unsigned sw, output int unsigned sh);
        sw = shadow.src_width;
        sh = shadow.src_height;
        if (sw < 2) sw = 2;
        if (sw > MAX_WIDTH) sw = MAX_WIDTH;
        if (sh < 1) sh = 1;
        if (sh > MAX_HEIGHT) sh = MAX_HEIGHT;
    endfunction

    function automatic t_out_word yuv_to_pixel(input int unsigned x, input int unsigned y,
            input logic [7:0] luma, input logic [7:0] cb, input logic [7:0] cr,
            input logic is_last);
        int         c, d, e;
        logic [7:0] r, g, b;
        longint     off;
        t_out_word  px;
        c = int'(luma) - 16;
        d = int'(cb) - 128;
        e = int'(cr) - 128;
        r = sat_channel(298 * c + 409 * e + 128);
        g = sat_channel(298 * c - 100 * d - 208 * e + 128);
        b = sat_channel(298 * c + 516 * d + 128);
        if (shadow.pixel_mode == MODE_RGB565) begin
            px.byte_count = BYTES_RGB565;
            px.pixel_word = {16'h0000, r[7:3], g[7:2], b[7:3]};
        end else begin
            px.byte_count = (shadow.pixel_mode == MODE_BGRX) ? BYTES_BGRX : BYTES_BGR;
            px.pixel_word = {8'h00, r, g, b};
        end
        off = longint'(y) * longint'(shadow.line_bytes) + longint'(x) * longint'(px.byte_count);
        px.fb_offset = off[OFF_W-1:0];
        px.last = is_last;
        return px;
    endfunction

    // Pushes the pixel writes of one macropixel, returns how many.
    function automatic int predict_macropixel(input t_in_word w);
        int unsigned sw, sh, show_w, show_h, pairs, x, y;
        bit          two;
        int          n;
        n = 0;
        frame_geometry(sw, sh);
        show_w = (sw < shadow.disp_width) ? sw : shadow.disp_width;
        show_h = (sh < shadow.disp_height) ? sh : shadow.disp_height;
        pairs = (sw + 1) >> 1;
        if (w.frame_start) begin
            col_pair = 0;
            row_idx = 0;
        end
        if (col_pair >= pairs) col_pair = 0;
        if (row_idx >= sh) row_idx = 0;
        x = col_pair * 2;
        y = row_idx;
        if (shadow.pixel_mode != MODE_NONE && y < show_h && x < show_w) begin
            two = (x + 1 < show_w);
            expected_pixels.push_back(yuv_to_pixel(x, y, w.luma_first, w.chroma_blue,
                                                   w.chroma_red, !two));
            n++;
            if (two) begin
                expected_pixels.push_back(yuv_to_pixel(x + 1, y, w.luma_second,
                                                       w.chroma_blue, w.chroma_red, 1'b1));
                n++;
            end
        end
        col_pair++;
        if (col_pair >= pairs) begin
            col_pair = 0;
            row_idx++;
            if (row_idx >= sh) row_idx = 0;
        end
        return n;
    endfunction

    always @(posedge i_clk) begin : accept_mon
        t_item_note note;
        int         n;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            macropixels_in++;
            note = fixed_notes.pop_front();
            n = predict_macropixel(i_in_word);
            if (note.n_fixed >= 0) begin
                repeat (n) void'(expected_pixels.pop_back());
                if (note.n_fixed >= 1) expected_pixels.push_back(note.fix0);
                if (note.n_fixed >= 2) expected_pixels.push_back(note.fix1);
            end
        end
    end

    always @(posedge i_clk) begin : result_mon
        t_out_word exp_px;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            pixels_checked++;
            if (expected_pixels.size() == 0) begin
                log_mismatch($sformatf("unexpected word off=%h pix=%h bc=%0d last=%b",
                             o_out_word.fb_offset, o_out_word.pixel_word,
                             o_out_word.byte_count, o_out_word.last));
            end else begin
                exp_px = expected_pixels.pop_front();
                if (o_out_word.fb_offset !== exp_px.fb_offset ||
                    o_out_word.pixel_word !== exp_px.pixel_word ||
                    o_out_word.byte_count !== exp_px.byte_count ||
                    o_out_word.last !== exp_px.last) begin
                    log_mismatch($sformatf(
                        "exp off=%h pix=%h bc=%0d last=%b, got off=%h pix=%h bc=%0d last=%b",
                        exp_px.fb_offset, exp_px.pixel_word, exp_px.byte_count, exp_px.last,
                        o_out_word.fb_offset, o_out_word.pixel_word,
                        o_out_word.byte_count, o_out_word.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (calm) begin
            stall_cnt = 0;
            i_out_ready <= 1'b1;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            stall_cnt = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            i_out_ready <= (stall_cnt == 0);
            if (stall_cnt > 0) stall_cnt--;
        end
    end

    task automatic send_macropixel(input t_in_word w, input int n_fixed,
                                   input t_out_word f0, input t_out_word f1);
        int         gap;
        t_item_note note;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        note.n_fixed = n_fixed;
        note.fix0 = f0;
        note.fix1 = f1;
        fixed_notes.push_back(note);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SRC_WIDTH:   shadow.src_width = data[DIM_W-1:0];
            CFG_SRC_HEIGHT:  shadow.src_height = data[DIM_W-1:0];
            CFG_DISP_WIDTH:  shadow.disp_width = data[DIM_W-1:0];
            CFG_DISP_HEIGHT: shadow.disp_height = data[DIM_W-1:0];
            CFG_LINE_BYTES:  shadow.line_bytes = data[LINE_W-1:0];
            CFG_PIXEL_MODE:  shadow.pixel_mode = data[MODE_W-1:0];
            default: ;
        endcase
    endtask

    // Spare indexes get junk every time; they must leave the setting alone.
    task automatic load_regs(input logic [14:0] sw, input logic [14:0] sh,
                             input logic [14:0] lw, input logic [14:0] lh,
                             input logic [14:0] lb, input logic [14:0] pm);
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DISP_WIDTH, lw);
        write_reg(CFG_DISP_HEIGHT, lh);
        write_reg(CFG_LINE_BYTES, lb);
        write_reg(CFG_PIXEL_MODE, pm);
        write_reg(CFG_SPARE_A, 15'($urandom_range(0, 32767)));
        write_reg(CFG_SPARE_B, 15'($urandom_range(0, 32767)));
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    function automatic void add_item(input t_in_word w, input int n_fixed,
                                     input t_out_word f0, input t_out_word f1);
        t_dir_row row;
        row.kind = ROW_ITEM;
        row.cfg = '0;
        row.w = w;
        row.n_fixed = n_fixed;
        row.fix0 = f0;
        row.fix1 = f1;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input t_cfg c);
        t_dir_row row;
        row.kind = ROW_CFG;
        row.cfg = c;
        row.w = '0;
        row.n_fixed = -1;
        row.fix0 = '0;
        row.fix1 = '0;
        dir_rows.push_back(row);
    endfunction

    initial begin : stimulus
        int          idx, n, pos, random_items;
        int unsigned sw, sh, frame_len;
        logic        fs;
        logic [14:0] r_sw, r_sh, r_lw, r_lh, r_lb, r_pm;
        random_items = 0;

        // Defaults after reset: black then white at the origin.
        add_item({1'b1, 8'd16, 8'd128, 8'd235, 8'd128}, 2,
                 {26'd0, 32'h0000_0000, BYTES_BGRX, 1'b0},
                 {26'd4, 32'h00FF_FFFF, BYTES_BGRX, 1'b1});
        add_item({1'b0, 8'd255, 8'd255, 8'd0, 8'd255}, -1, '0, '0);
        add_item({1'b0, 8'd0, 8'd0, 8'd255, 8'd0}, -1, '0, '0);
        add_item({1'b1, 8'd128, 8'd64, 8'd200, 8'd192}, -1, '0, '0);
        // Odd source width: last macropixel of a row writes the even pixel only.
        add_cfg('{13'd5, 13'd3, 13'd8, 13'd2, 15'd40, MODE_BGR});
        add_item({1'b1, 8'd81, 8'd90, 8'd145, 8'd240}, -1, '0, '0);
        add_item({1'b0, 8'd41, 8'd240, 8'd210, 8'd110}, -1, '0, '0);
        add_item({1'b0, 8'd170, 8'd166, 8'd30, 8'd16}, -1, '0, '0);
        add_item({1'b0, 8'd235, 8'd16, 8'd16, 8'd235}, -1, '0, '0);
        add_item({1'b0, 8'd100, 8'd200, 8'd50, 8'd60}, -1, '0, '0);
        add_item({1'b0, 8'd1, 8'd254, 8'd254, 8'd1}, -1, '0, '0);
        // Third line is below the display.
        add_item({1'b0, 8'd255, 8'd255, 8'd255, 8'd255}, 0, '0, '0);
        add_item({1'b0, 8'd0, 8'd0, 8'd0, 8'd0}, 0, '0, '0);
        add_item({1'b0, 8'd128, 8'd128, 8'd128, 8'd128}, 0, '0, '0);
        add_item({1'b0, 8'd60, 8'd70, 8'd80, 8'd90}, -1, '0, '0);
        // No-write mode still advances the position.
        add_cfg('{13'd4, 13'd2, 13'd4, 13'd2, 15'd16, MODE_NONE});
        add_item({1'b1, 8'd200, 8'd30, 8'd90, 8'd250}, 0, '0, '0);
        add_item({1'b0, 8'd10, 8'd220, 8'd180, 8'd40}, 0, '0, '0);
        add_cfg('{13'd4, 13'd2, 13'd4, 13'd2, 15'd16, MODE_RGB565});
        add_item({1'b0, 8'd255, 8'd0, 8'd16, 8'd255}, -1, '0, '0);
        add_item({1'b0, 8'd16, 8'd255, 8'd235, 8'd0}, -1, '0, '0);
        // Zero display width, then source sizes below range with a huge display.
        add_cfg('{13'd0, 13'd0, 13'd0, 13'd8191, 15'd100, MODE_BGRX});
        add_item({1'b1, 8'd120, 8'd130, 8'd140, 8'd150}, 0, '0, '0);
        add_item({1'b0, 8'd50, 8'd60, 8'd70, 8'd80}, 0, '0, '0);
        add_cfg('{13'd0, 13'd0, 13'd8191, 13'd8191, 15'd32767, MODE_RGB565});
        add_item({1'b0, 8'd255, 8'd0, 8'd0, 8'd255}, -1, '0, '0);
        add_item({1'b0, 8'd0, 8'd255, 8'd255, 8'd0}, -1, '0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle();
                load_regs(15'(dir_rows[i].cfg.src_width), 15'(dir_rows[i].cfg.src_height),
                          15'(dir_rows[i].cfg.disp_width), 15'(dir_rows[i].cfg.disp_height),
                          15'(dir_rows[i].cfg.line_bytes), 15'(dir_rows[i].cfg.pixel_mode));
            end else begin
                send_macropixel(dir_rows[i].w, dir_rows[i].n_fixed,
                                dir_rows[i].fix0, dir_rows[i].fix1);
            end
        end

        while (random_items < RANDOM_TARGET) begin
            case ($urandom_range(0, 9))
                0: r_sw = 15'($urandom_range(0, 1));
                1: r_sw = ($urandom_range(0, 1) == 0) ? 15'd8191 : 15'd4097;
                default: r_sw = 15'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 9))
                0: r_sh = 15'd0;
                1: r_sh = 15'd8191;
                default: r_sh = 15'($urandom_range(1, 5));
            endcase
            case ($urandom_range(0, 9))
                0: r_lw = 15'd0;
                1: r_lw = 15'd8191;
                2: r_lw = 15'd4096;
                default: r_lw = 15'($urandom_range(1, 14));
            endcase
            case ($urandom_range(0, 9))
                0: r_lh = 15'd0;
                1: r_lh = 15'd8191;
                default: r_lh = 15'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0: r_lb = 15'd0;
                1: r_lb = 15'd32767;
                2: r_lb = 15'($urandom_range(0, 32767));
                default: r_lb = 15'($urandom_range(1, 64));
            endcase
            r_pm = ($urandom_range(0, 99) < 15) ? 15'(MODE_NONE) : 15'($urandom_range(0, 2));
            // Upper data bits beyond each register width are dropped.
            r_sw = r_sw | (15'($urandom_range(0, 3)) << 13);
            r_sh = r_sh | (15'($urandom_range(0, 3)) << 13);
            r_lw = r_lw | (15'($urandom_range(0, 3)) << 13);
            r_lh = r_lh | (15'($urandom_range(0, 3)) << 13);
            r_pm = r_pm | (15'($urandom_range(0, 8191)) << 2);

            calm = 1'b0;
            settle();
            load_regs(r_sw, r_sh, r_lw, r_lh, r_lb, r_pm);
            frame_geometry(sw, sh);
            frame_len = ((sw + 1) >> 1) * sh;
            calm = ($urandom_range(0, 5) == 0);
            n = $urandom_range(20, 100);
            pos = ($urandom_range(0, 9) < 7) ? 0 : 1;
            for (idx = 0; idx < n; idx++) begin
                fs = (pos == 0) || ($urandom_range(0, 29) == 0);
                if (fs) pos = 0;
                send_macropixel({fs, pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                                -1, '0, '0);
                pos = (pos + 1) % frame_len;
            end
            random_items += n;
        end

        calm = 1'b0;
        settle();
        $display("covered %0d macropixels and %0d pixel words over %0d register loads",
                 macropixels_in, pixels_checked, settings_loaded);
        $display("modes, crops, odd edges, row wraps and clamped sizes; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("timeout with %0d words outstanding", expected_pixels.size());
        $display("status: fail");
        $finish;
    end

endmodule

[yuyv_to_framebuffer_pixel_writer.f]
+incdir+hw/rtl
hw/rtl/ytfpw_pkg.sv
hw/rtl/ytfpw_cfg.sv
hw/rtl/ytfpw_pos.sv
hw/rtl/ytfpw_pixel.sv
hw/rtl/yuyv_to_framebuffer_pixel_writer.sv
bench/tb_yuyv_to_framebuffer_pixel_writer.sv
